/* sv/twwu_pkg.sv */
// Shared types and constants of the text window writer.
`default_nettype none

package twwu_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_WIN_LEFT  = 3'd0,
		REG_WIN_TOP   = 3'd1,
		REG_WIN_COLS  = 3'd2,
		REG_WIN_ROWS  = 3'd3,
		REG_TEXT_ATTR = 3'd4
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [6:0] WIN_LEFT_RST  = 7'd0;
	localparam logic [4:0] WIN_TOP_RST   = 5'd0;
	localparam logic [6:0] WIN_COLS_RST  = 7'd80;
	localparam logic [4:0] WIN_ROWS_RST  = 5'd25;
	localparam logic [7:0] TEXT_ATTR_RST = 8'h07;

	typedef struct packed {
		logic [6:0] win_left;
		logic [4:0] win_top;
		logic [6:0] win_cols;
		logic [4:0] win_rows;
		logic [7:0] text_attr;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] symbol;
		logic [6:0] read_col;
		logic [4:0] read_row;
		logic       read_ok;
	} item_t;

	typedef struct packed {
		logic [6:0]  cell_col;
		logic [4:0]  cell_row;
		logic [15:0] cell_value;
		logic        scrolled;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
	} res_t;

endpackage

`default_nettype wire

/* sv/twwu_queue.sv */
// Small synchronous FIFO used for the command and result queues.
`default_nettype none

module twwu_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic      [DATA_W-1:0] head,
	output logic                   full,
	output logic                   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/twwu_front.sv */
// Front end: configuration registers and intake of operations into the command queue.
`default_nettype none

module twwu_front
	import twwu_pkg::*;
#(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            op,
	input  wire logic [7:0]            symbol,
	input  wire logic [6:0]            read_col,
	input  wire logic [4:0]            read_row,
	input  wire logic                  init_busy,
	input  wire logic                  q_full,
	output logic                       q_push,
	output item_t                      q_item,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Nothing enters while the back end is still zeroing the screen after reset.
	assign full   = q_full || init_busy;
	assign q_push = push && !full;

	always_comb begin
		q_item.op       = op_t'(op);
		q_item.symbol   = symbol;
		q_item.read_col = read_col;
		q_item.read_row = read_row;
		q_item.read_ok  = (int'(read_col) < SCREEN_COLS) && (int'(read_row) < SCREEN_ROWS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_left  <= WIN_LEFT_RST;
			cfg_q.win_top   <= WIN_TOP_RST;
			cfg_q.win_cols  <= WIN_COLS_RST;
			cfg_q.win_rows  <= WIN_ROWS_RST;
			cfg_q.text_attr <= TEXT_ATTR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIN_LEFT:  cfg_q.win_left  <= cfg_data[6:0];
				REG_WIN_TOP:   cfg_q.win_top   <= cfg_data[4:0];
				REG_WIN_COLS:  cfg_q.win_cols  <= cfg_data[6:0];
				REG_WIN_ROWS:  cfg_q.win_rows  <= cfg_data[4:0];
				REG_TEXT_ATTR: cfg_q.text_attr <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/twwu_back.sv */
// Back end: screen memory, cursor and the sequencer that executes queued operations.
`default_nettype none

module twwu_back
	import twwu_pkg::*;
#(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  cmd_empty,
	input  wire item_t cmd_item,
	output logic       cmd_pop,
	input  wire logic  res_full,
	output logic       res_push,
	output res_t       res_item,
	output logic       init_busy
);

	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(SCREEN_COLS + 1);
	localparam int RW    = $clog2(SCREEN_ROWS + 1);
	localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);
	localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_SCROLL,
		ST_CLEAR
	} state_t;

	state_t      state_q;
	item_t       cmd_q;
	logic [CW-1:0] cur_x_q;
	logic [RW-1:0] cur_y_q;
	logic [AW-1:0] init_addr_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] walk_last_q;
	logic [RW-1:0] rows_left_q;
	logic [AW-1:0] row_start_q;
	logic          pend_v_s1;
	logic [AW-1:0] pend_addr_s1;

	// Effective window, resolved from the registers.
	logic          off_screen;
	logic [6:0]    cols_req;
	logic [4:0]    rows_req;
	logic [CW-1:0] eff_left;
	logic [CW-1:0] eff_cols;
	logic [RW-1:0] eff_top;
	logic [RW-1:0] eff_rows;
	logic [CW-1:0] win_left_q;
	logic [CW-1:0] win_cols_q;
	logic [RW-1:0] win_top_q;
	logic [RW-1:0] win_rows_q;
	logic [AW-1:0] win_base_q;

	// Put datapath.
	logic [CW-1:0] cx_c;
	logic [RW-1:0] cy_c;
	logic [CW-1:0] nx_c;
	logic [RW-1:0] ny_c;
	logic          row_end_c;
	logic          bottom_c;
	logic [CW-1:0] new_x_c;
	logic [RW-1:0] new_y_c;
	logic [CW-1:0] put_col_c;
	logic [RW-1:0] put_row_c;
	logic [AW-1:0] put_addr_c;
	logic [AW-1:0] read_addr_c;
	logic          walk_row_end;

	// Cell memory.
	logic [15:0]   mem [CELLS];
	logic [15:0]   mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	always_comb begin
		off_screen = (int'(cfg.win_left) >= SCREEN_COLS) || (int'(cfg.win_top) >= SCREEN_ROWS);
		cols_req   = (cfg.win_cols == '0) ? 7'd1 : cfg.win_cols;
		rows_req   = (cfg.win_rows == '0) ? 5'd1 : cfg.win_rows;
		if (off_screen) begin
			eff_left = '0;
			eff_top  = '0;
			eff_cols = CW'(SCREEN_COLS);
			eff_rows = RW'(SCREEN_ROWS);
		end else begin
			eff_left = CW'(cfg.win_left);
			eff_top  = RW'(cfg.win_top);
			eff_cols = (int'(cols_req) > SCREEN_COLS - int'(cfg.win_left)) ?
				CW'(SCREEN_COLS - int'(cfg.win_left)) : CW'(cols_req);
			eff_rows = (int'(rows_req) > SCREEN_ROWS - int'(cfg.win_top)) ?
				RW'(SCREEN_ROWS - int'(cfg.win_top)) : RW'(rows_req);
		end
	end

	// The user must keep the registers unchanged while an op waits to execute; nothing here
	// enforces it. They may change during a scroll or clear walk, which keeps its own bounds.
	always_ff @(posedge clk) begin
		win_left_q <= eff_left;
		win_top_q  <= eff_top;
		win_cols_q <= eff_cols;
		win_rows_q <= eff_rows;
		win_base_q <= AW'(int'(eff_top) * SCREEN_COLS + int'(eff_left));
	end

	always_comb begin
		cx_c       = (cur_x_q >= win_cols_q) ? win_cols_q - 1'b1 : cur_x_q;
		cy_c       = (cur_y_q >= win_rows_q) ? win_rows_q - 1'b1 : cur_y_q;
		nx_c       = cx_c + 1'b1;
		ny_c       = cy_c + 1'b1;
		row_end_c  = (nx_c == win_cols_q);
		bottom_c   = row_end_c && (ny_c == win_rows_q);
		new_x_c    = row_end_c ? '0 : nx_c;
		new_y_c    = (row_end_c && !bottom_c) ? ny_c : cy_c;
		put_col_c  = win_left_q + cx_c;
		put_row_c  = win_top_q + cy_c;
		put_addr_c = win_base_q + AW'(int'(cy_c) * SCREEN_COLS) + AW'(cx_c);
		read_addr_c = AW'(int'(cmd_q.read_row) * SCREEN_COLS + int'(cmd_q.read_col));
		walk_row_end = (col_q == walk_last_q);
	end

	assign init_busy = (state_q == ST_INIT);
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty && !res_full;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pend_addr_s1;
		mem_wdata = mem_rdata_q;
		mem_re    = 1'b0;
		mem_raddr = read_addr_c;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_addr_q;
				mem_wdata = '0;
			end
			ST_EXEC: begin
				if (cmd_q.op == OP_PUT) begin
					mem_we    = 1'b1;
					mem_waddr = put_addr_c;
					mem_wdata = {cfg.text_attr, cmd_q.symbol};
				end
				mem_re = (cmd_q.op == OP_READ) && cmd_q.read_ok;
			end
			ST_SCROLL: begin
				mem_re    = 1'b1;
				mem_raddr = row_start_q + COLS_A + AW'(col_q);
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = row_start_q + AW'(col_q);
				mem_wdata = '0;
			end
			default: ;
		endcase
		// The write half of a scroll copy lands in the cycle after its read.
		if (pend_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = pend_addr_s1;
			mem_wdata = mem_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_comb begin
		res_item            = '0;
		res_item.cursor_col = 7'(cur_x_q);
		res_item.cursor_row = 5'(cur_y_q);
		res_push            = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				res_push = !((cmd_q.op == OP_READ) && cmd_q.read_ok);
				if (cmd_q.op == OP_PUT) begin
					res_item.cell_col   = 7'(put_col_c);
					res_item.cell_row   = 5'(put_row_c);
					res_item.cell_value = {cfg.text_attr, cmd_q.symbol};
					res_item.scrolled   = bottom_c;
					res_item.cursor_col = 7'(new_x_c);
					res_item.cursor_row = 5'(new_y_c);
				end else if (cmd_q.op == OP_READ) begin
					res_item.cell_col = cmd_q.read_col;
					res_item.cell_row = cmd_q.read_row;
				end
			end
			ST_RDATA: begin
				res_push            = 1'b1;
				res_item.cell_col   = cmd_q.read_col;
				res_item.cell_row   = cmd_q.read_row;
				res_item.cell_value = mem_rdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cmd_q        <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			init_addr_q  <= '0;
			col_q        <= '0;
			walk_last_q  <= '0;
			rows_left_q  <= '0;
			row_start_q  <= '0;
			pend_v_s1    <= 1'b0;
			pend_addr_s1 <= '0;
		end else begin
			pend_v_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_INIT: begin
					init_addr_q <= init_addr_q + 1'b1;
					if (init_addr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q   <= cmd_item;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					row_start_q <= win_base_q;
					col_q       <= '0;
					walk_last_q <= win_cols_q - 1'b1;
					unique case (cmd_q.op)
						OP_PUT: begin
							cur_x_q     <= new_x_c;
							cur_y_q     <= new_y_c;
							rows_left_q <= win_rows_q - 1'b1;
							// A single-row window has nothing to copy.
							state_q <= (bottom_c && (win_rows_q != RW'(1))) ? ST_SCROLL : ST_IDLE;
						end
						OP_CLEAR: begin
							rows_left_q <= win_rows_q;
							state_q     <= ST_CLEAR;
						end
						OP_READ: begin
							state_q <= cmd_q.read_ok ? ST_RDATA : ST_IDLE;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RDATA: begin
					state_q <= ST_IDLE;
				end
				ST_SCROLL, ST_CLEAR: begin
					if (state_q == ST_SCROLL) begin
						pend_addr_s1 <= row_start_q + AW'(col_q);
					end
					if (walk_row_end) begin
						col_q       <= '0;
						row_start_q <= row_start_q + COLS_A;
						rows_left_q <= rows_left_q - 1'b1;
						if (rows_left_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pend_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 |-> (state_q == ST_SCROLL || state_q == ST_IDLE))
		else $error("scroll write-back collides with another memory write");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_cursor_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && cmd_q.op == OP_PUT) |=>
		(cur_x_q < win_cols_q && cur_y_q < win_rows_q))
		else $error("cursor left the window after a put");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL || state_q == ST_CLEAR) |->
		(col_q <= walk_last_q && rows_left_q != '0))
		else $error("window walk ran outside the window");

endmodule

`default_nettype wire

/* sv/text_window_writer_unit.sv */
// Text window writer: keeps a text screen and a window cursor, executing put, clear and read ops.
// Every operation yields exactly one result beat. A put, a read of an off-screen cell and a
// no-op are popped in the idle state and finish in the execute state; an on-screen read adds
// a read-data state that returns the cell from the registered memory read. A put that scrolls
// copies rows - 1 rows of the effective window up and a clear zeroes all its rows, one cell
// per cycle; further ops wait in the command queue meanwhile. After reset the screen is zeroed
// one cell per cycle with full held high; configuration writes are taken throughout.
// Configuration may only be written while no op is in flight.
`default_nettype none

module text_window_writer_unit
	import twwu_pkg::*;
#(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            op,
	input  wire logic [7:0]            symbol,
	input  wire logic [6:0]            read_col,
	input  wire logic [4:0]            read_row,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [6:0]                 cell_col,
	output logic [4:0]                 cell_row,
	output logic [15:0]                cell_value,
	output logic                       scrolled,
	output logic [6:0]                 cursor_col,
	output logic [4:0]                 cursor_row
);

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(res_t);

	cfg_t              cfg;
	logic              init_busy;
	logic              cmdq_push;
	item_t             cmdq_in;
	logic              cmdq_full;
	logic              cmdq_empty;
	logic              cmdq_pop;
	logic [ITEM_W-1:0] cmdq_head;
	logic              resq_push;
	res_t              resq_in;
	logic              resq_full;
	logic [RES_W-1:0]  resq_head;
	res_t              res_out;

	twwu_front #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.op       (op),
		.symbol   (symbol),
		.read_col (read_col),
		.read_row (read_row),
		.init_busy(init_busy),
		.q_full   (cmdq_full),
		.q_push   (cmdq_push),
		.q_item   (cmdq_in),
		.cfg      (cfg)
	);

	twwu_queue #(
		.DATA_W(ITEM_W),
		.DEPTH (2)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmdq_push),
		.push_data(ITEM_W'(cmdq_in)),
		.pop      (cmdq_pop),
		.head     (cmdq_head),
		.full     (cmdq_full),
		.empty    (cmdq_empty)
	);

	twwu_back #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_empty(cmdq_empty),
		.cmd_item (item_t'(cmdq_head)),
		.cmd_pop  (cmdq_pop),
		.res_full (resq_full),
		.res_push (resq_push),
		.res_item (resq_in),
		.init_busy(init_busy)
	);

	twwu_queue #(
		.DATA_W(RES_W),
		.DEPTH (2)
	) u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (resq_push),
		.push_data(RES_W'(resq_in)),
		.pop      (pop),
		.head     (resq_head),
		.full     (resq_full),
		.empty    (empty)
	);

	assign res_out    = res_t'(resq_head);
	assign cell_col   = res_out.cell_col;
	assign cell_row   = res_out.cell_row;
	assign cell_value = res_out.cell_value;
	assign scrolled   = res_out.scrolled;
	assign cursor_col = res_out.cursor_col;
	assign cursor_row = res_out.cursor_row;

endmodule

`default_nettype wire
